// ===== hdl/bcc_pkg.sv =====
// Shared types and constants of the button click classifier.
// Used by bcc_core, button_click_classifier_unit, bcc_checker and testbench; no dependencies.
package bcc_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int EVENT_WIDTH = 3;
   localparam int COUNT_WIDTH = 8;

   typedef logic [TIMER_WIDTH-1:0]   timer_type;
   typedef logic [CFG_WIDTH-1:0]     cfg_type;
   typedef logic [CMP_WIDTH-1:0]     cmp_type;
   typedef logic [CSR_IDX_WIDTH-1:0] csr_idx_type;
   typedef logic [EVENT_WIDTH-1:0]   event_type;
   typedef logic [COUNT_WIDTH-1:0]   count_type;

   localparam timer_type TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // register indexes
   localparam csr_idx_type CSR_DEBOUNCE  = 3'd0;
   localparam csr_idx_type CSR_HOLD      = 3'd1;
   localparam csr_idx_type CSR_REPEAT    = 3'd2;
   localparam csr_idx_type CSR_MIN_CLICK = 3'd3;
   localparam csr_idx_type CSR_IDLE      = 3'd4;

   // reset values
   localparam cfg_type DEBOUNCE_RST  = 16'd50;
   localparam cfg_type HOLD_RST      = 16'd1000;
   localparam cfg_type REPEAT_RST    = 16'd400;
   localparam cfg_type MIN_CLICK_RST = 16'd150;

   // event codes
   localparam event_type EV_NONE   = 3'd0;
   localparam event_type EV_SINGLE = 3'd1;
   localparam event_type EV_DOUBLE = 3'd2;
   localparam event_type EV_TRIPLE = 3'd3;
   localparam event_type EV_HOLD   = 3'd4;

   typedef struct packed {
      event_type event_code;
      logic      pressed;
   } result_type;

endpackage

// ===== hdl/bcc_core.sv =====
// Debounce, press timing and click classification state of the classifier.
// Holds the configuration registers; result is combinational from state and pin.
// Depends on bcc_pkg.
module bcc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 pin_level,
   input  logic                 csr_write_enable,
   input  bcc_pkg::csr_idx_type csr_index,
   input  bcc_pkg::cfg_type     csr_write_data,
   output bcc_pkg::result_type  result
);
   import bcc_pkg::*;

   cfg_type   debounce_ticks_ff, hold_ticks_ff, repeat_ticks_ff, min_click_ticks_ff;
   logic      idle_level_ff;

   logic      stable_level_ff, stable_level_in;
   cfg_type   debounce_count_ff, debounce_count_in;
   logic      debounce_active_ff, debounce_active_in;
   timer_type since_press_ff, since_press_in;
   timer_type hold_timer_ff, hold_timer_in;
   logic      hold_armed_ff, hold_armed_in;
   timer_type press_length_ff, press_length_in;
   count_type press_count_ff, press_count_in;
   logic      release_ready_ff, release_ready_in;
   logic      count_restart_ff, count_restart_in;
   logic      hold_seen_ff, hold_seen_in;
   event_type event_in;

   function automatic timer_type sat_inc(input timer_type v);
      sat_inc = (v == TIMER_MAX) ? v : v + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff  <= DEBOUNCE_RST;
         hold_ticks_ff      <= HOLD_RST;
         repeat_ticks_ff    <= REPEAT_RST;
         min_click_ticks_ff <= MIN_CLICK_RST;
         idle_level_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE:  debounce_ticks_ff  <= csr_write_data;
            CSR_HOLD:      hold_ticks_ff      <= csr_write_data;
            CSR_REPEAT:    repeat_ticks_ff    <= csr_write_data;
            CSR_MIN_CLICK: min_click_ticks_ff <= csr_write_data;
            CSR_IDLE:      idle_level_ff      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      stable_level_in    = stable_level_ff;
      debounce_count_in  = debounce_count_ff;
      debounce_active_in = debounce_active_ff;
      hold_armed_in      = hold_armed_ff;
      press_length_in    = press_length_ff;
      press_count_in     = press_count_ff;
      release_ready_in   = release_ready_ff;
      count_restart_in   = count_restart_ff;
      hold_seen_in       = hold_seen_ff;
      event_in           = EV_NONE;

      since_press_in = sat_inc(since_press_ff);
      hold_timer_in  = hold_armed_ff ? sat_inc(hold_timer_ff) : hold_timer_ff;

      // debounce: re-check the pin once the count has run out
      if (!debounce_active_ff && (pin_level != stable_level_ff)) begin
         debounce_active_in = 1'b1;
         debounce_count_in  = '0;
      end
      if (debounce_active_in) begin
         if (debounce_count_in >= debounce_ticks_ff) begin
            debounce_active_in = 1'b0;
            debounce_count_in  = '0;
            if (pin_level != stable_level_ff) begin
               stable_level_in = ~stable_level_ff;
               if (stable_level_in == idle_level_ff) begin
                  press_length_in  = since_press_in;
                  release_ready_in = 1'b1;
                  hold_armed_in    = 1'b0;
               end else begin
                  since_press_in   = '0;
                  hold_timer_in    = '0;
                  hold_armed_in    = 1'b1;
                  hold_seen_in     = 1'b0;
                  press_length_in  = '0;
                  release_ready_in = 1'b0;
                  if (count_restart_ff) begin
                     press_count_in   = count_type'(1);
                     count_restart_in = 1'b0;
                  end else if (press_count_ff != COUNT_MAX) begin
                     press_count_in = press_count_ff + 1'b1;
                  end
               end
            end
         end else begin
            debounce_count_in = debounce_count_in + 1'b1;
         end
      end

      if (hold_armed_in && !release_ready_in &&
          (cmp_type'(hold_timer_in) > cmp_type'(hold_ticks_ff))) begin
         event_in      = EV_HOLD;
         hold_timer_in = '0;
         hold_seen_in  = 1'b1;
      end

      if (release_ready_in && !hold_seen_in &&
          (cmp_type'(since_press_in) > cmp_type'(repeat_ticks_ff))) begin
         release_ready_in = 1'b0;
         count_restart_in = 1'b1;
         case (press_count_in)
            count_type'(1): begin
               if (cmp_type'(press_length_in) > cmp_type'(min_click_ticks_ff))
                  event_in = EV_SINGLE;
            end
            count_type'(2): event_in = EV_DOUBLE;
            count_type'(3): event_in = EV_TRIPLE;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff    <= 1'b0;
         debounce_count_ff  <= '0;
         debounce_active_ff <= 1'b0;
         since_press_ff     <= '0;
         hold_timer_ff      <= '0;
         hold_armed_ff      <= 1'b0;
         press_length_ff    <= '0;
         press_count_ff     <= '0;
         release_ready_ff   <= 1'b0;
         count_restart_ff   <= 1'b0;
         hold_seen_ff       <= 1'b0;
      end else if (step) begin
         stable_level_ff    <= stable_level_in;
         debounce_count_ff  <= debounce_count_in;
         debounce_active_ff <= debounce_active_in;
         since_press_ff     <= since_press_in;
         hold_timer_ff      <= hold_timer_in;
         hold_armed_ff      <= hold_armed_in;
         press_length_ff    <= press_length_in;
         press_count_ff     <= press_count_in;
         release_ready_ff   <= release_ready_in;
         count_restart_ff   <= count_restart_in;
         hold_seen_ff       <= hold_seen_in;
      end
   end

   assign result.event_code = event_in;
   assign result.pressed    = stable_level_in ^ idle_level_ff;

endmodule

// ===== hdl/button_click_classifier_unit.sv =====
// Button click classifier: one tick sample in, one event/pressed transaction out.
// An accepted sample's result is registered in the output buffer. Throughput: 1
// sample per cycle while req_stall is low, as bcc_core updates its state on each
// accepted sample; a two-entry output buffer keeps input flowing while a result
// waits. Synchronous active-high reset restores the register defaults and clears all
// timers, counters and the output buffer. Depends on bcc_pkg and bcc_core.
module button_click_classifier_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_pin_level,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bcc_pkg::event_type   rsp_event_code,
   output logic                 rsp_pressed,
   input  logic                 csr_write_enable,
   input  bcc_pkg::csr_idx_type csr_index,
   input  bcc_pkg::cfg_type     csr_write_data
);
   import bcc_pkg::*;

   logic       req_accept, out_free;
   result_type core_result;
   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !out_valid_ff || !rsp_stall;

   bcc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (req_accept),
      .pin_level        (req_pin_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .result           (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : core_result;
      end else if (req_accept) begin
         skid_data_ff <= core_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_code = out_data_ff.event_code;
   assign rsp_pressed    = out_data_ff.pressed;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_code <= EV_HOLD))
      else $error("event code out of range");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && req_accept) |=> (skid_valid_ff && out_valid_ff))
      else $error("transaction dropped while output stalled");

endmodule

// ===== test/bcc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the button click classifier: watches the register port and both channels.
// It predicts each tick's event and pressed flag and compares them with the results.
// Depends on bcc_pkg.
module bcc_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_pin_level,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bcc_pkg::event_type   rsp_event_code,
   input  logic                 rsp_pressed,
   input  logic                 csr_write_enable,
   input  bcc_pkg::csr_idx_type csr_index,
   input  bcc_pkg::cfg_type     csr_write_data,
   output int unsigned          errors,
   output int unsigned          pending,
   output int unsigned          checked,
   output int unsigned          singles,
   output int unsigned          doubles,
   output int unsigned          triples,
   output int unsigned          holds
);
   import bcc_pkg::*;

   cfg_type   debounce_cfg, hold_cfg, repeat_cfg, min_click_cfg;
   logic      idle_cfg;

   logic      accepted_level, bounce_busy, hold_live, release_wait, new_sequence, held;
   cfg_type   bounce_cnt;
   timer_type age, hold_cnt, last_len;
   count_type clicks;

   result_type expected_results[$];

   task automatic report(input string msg);
      if (errors < 20) begin
         $display("%0t ns: %s", $time, msg);
      end
      errors++;
   endtask

   function automatic result_type classify_tick(input logic pin);
      event_type  ev;
      result_type r;
      ev = EV_NONE;
      if (age != TIMER_MAX) age++;
      if (hold_live && hold_cnt != TIMER_MAX) hold_cnt++;

      if (!bounce_busy && pin != accepted_level) begin
         bounce_busy = 1'b1;
         bounce_cnt  = '0;
      end
      if (bounce_busy) begin
         if (bounce_cnt >= debounce_cfg) begin
            bounce_busy = 1'b0;
            bounce_cnt  = '0;
            if (pin != accepted_level) begin
               accepted_level = ~accepted_level;
               if (accepted_level == idle_cfg) begin
                  last_len     = age;
                  release_wait = 1'b1;
                  hold_live    = 1'b0;
               end else begin
                  age       = '0;
                  hold_cnt  = '0;
                  hold_live = 1'b1;
                  held      = 1'b0;
                  last_len  = '0;
                  if (new_sequence) begin
                     clicks       = count_type'(1);
                     new_sequence = 1'b0;
                  end else if (clicks != COUNT_MAX) begin
                     clicks++;
                  end
                  release_wait = 1'b0;
               end
            end
         end else begin
            bounce_cnt++;
         end
      end

      if (hold_live && !release_wait && hold_cnt > hold_cfg) begin
         ev       = EV_HOLD;
         hold_cnt = '0;
         held     = 1'b1;
      end

      // four or more presses, and a short single, end the sequence silently
      if (release_wait && age > repeat_cfg && !held) begin
         release_wait = 1'b0;
         new_sequence = 1'b1;
         if (clicks == 1) begin
            if (last_len > min_click_cfg) ev = EV_SINGLE;
         end else if (clicks == 2) begin
            ev = EV_DOUBLE;
         end else if (clicks == 3) begin
            ev = EV_TRIPLE;
         end
      end

      r.event_code = ev;
      r.pressed    = (accepted_level != idle_cfg);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         debounce_cfg   = DEBOUNCE_RST;
         hold_cfg       = HOLD_RST;
         repeat_cfg     = REPEAT_RST;
         min_click_cfg  = MIN_CLICK_RST;
         idle_cfg       = 1'b0;
         accepted_level = 1'b0;
         bounce_busy    = 1'b0;
         bounce_cnt     = '0;
         age            = '0;
         hold_cnt       = '0;
         hold_live      = 1'b0;
         last_len       = '0;
         clicks         = '0;
         release_wait   = 1'b0;
         new_sequence   = 1'b0;
         held           = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEBOUNCE:  debounce_cfg  = csr_write_data;
               CSR_HOLD:      hold_cfg      = csr_write_data;
               CSR_REPEAT:    repeat_cfg    = csr_write_data;
               CSR_MIN_CLICK: min_click_cfg = csr_write_data;
               CSR_IDLE:      idle_cfg      = csr_write_data[0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report("result transaction with nothing expected");
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (rsp_event_code != want.event_code) begin
                  report($sformatf("event_code mismatch: expected %0d, got %0d",
                                   want.event_code, rsp_event_code));
               end
               if (rsp_pressed != want.pressed) begin
                  report($sformatf("pressed mismatch: expected %0d, got %0d",
                                   want.pressed, rsp_pressed));
               end
               case (want.event_code)
                  EV_SINGLE: singles++;
                  EV_DOUBLE: doubles++;
                  EV_TRIPLE: triples++;
                  EV_HOLD:   holds++;
                  default: ;
               endcase
            end
         end

         if (req_valid && !req_stall) begin
            expected_results.push_back(classify_tick(req_pin_level));
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the button click classifier testbench: clock, reset, tick stimulus, register
// settings and the verdict. Depends on bcc_pkg, bcc_checker and button_click_classifier_unit.
module testbench;
   import bcc_pkg::*;

   localparam int          LONG_HOLD_OFF  = 300;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          SETTLE_CYCLES  = 4;
   localparam csr_idx_type CSR_SPARE      = 3'd7;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_pin_level    = 1'b0;
   logic        rsp_stall        = 1'b0;
   logic        csr_write_enable = 1'b0;
   csr_idx_type csr_index        = CSR_DEBOUNCE;
   cfg_type     csr_write_data   = '0;

   logic        req_stall, rsp_valid, rsp_pressed;
   event_type   rsp_event_code;

   int unsigned errors, pending, checked, singles, doubles, triples, holds;
   int unsigned sent = 0;
   bit          tx_gaps = 1'b0, rx_gaps = 1'b0, hold_off_req = 1'b0;
   int          deb_now = int'(DEBOUNCE_RST), hold_now = int'(HOLD_RST);
   int          rep_now = int'(REPEAT_RST), min_now = int'(MIN_CLICK_RST);
   logic        idle_now = 1'b0;

   button_click_classifier_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .rsp_pressed      (rsp_pressed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bcc_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .rsp_pressed      (rsp_pressed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .errors           (errors),
      .pending          (pending),
      .checked          (checked),
      .singles          (singles),
      .doubles          (doubles),
      .triples          (triples),
      .holds            (holds)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic send_tick(input logic level);
      int gap;
      gap = tx_gaps ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pin_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // occasional one-tick bounce ahead of the steady level
   task automatic send_run(input logic level, input int n);
      if (n > 2 && $urandom_range(0, 5) == 0) send_tick(~level);
      repeat (n) send_tick(level);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int deb, input int hold, input int rep, input int min_len,
                            input logic idle);
      csr_idx_type idx [6];
      cfg_type     val [6];
      drain();
      idx = '{CSR_SPARE, CSR_DEBOUNCE, CSR_HOLD, CSR_REPEAT, CSR_MIN_CLICK, CSR_IDLE};
      val = '{cfg_type'($urandom), cfg_type'(deb), cfg_type'(hold), cfg_type'(rep),
              cfg_type'(min_len), cfg_type'($urandom)};
      val[5][0] = idle;
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_write_data   <= val[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      deb_now  = deb;
      hold_now = hold;
      rep_now  = rep;
      min_now  = min_len;
      idle_now = idle;
   endtask

   // mostly click bursts and long presses, some pin noise
   task automatic random_phase(input int n);
      int   stop, presses, kind;
      logic down;
      stop = sent + n;
      down = ~idle_now;
      while (sent < stop) begin
         tx_gaps = ($urandom_range(0, 3) != 0);
         rx_gaps = ($urandom_range(0, 3) != 0);
         kind    = $urandom_range(0, 9);
         if (kind < 2) begin
            repeat ($urandom_range(1, 8)) send_tick(logic'($urandom_range(0, 1)));
         end else if (kind < 4) begin
            send_run(down, $urandom_range(deb_now + hold_now + 2, deb_now + 3 * hold_now + 4));
            send_run(~down, $urandom_range(deb_now + 1, deb_now + rep_now + 4));
         end else begin
            presses = $urandom_range(1, 4);
            repeat (presses) begin
               send_run(down, $urandom_range(deb_now + 1, deb_now + min_now + 3));
               send_run(~down, $urandom_range(deb_now + 1, deb_now + 2));
            end
            send_run(~down, deb_now + rep_now + $urandom_range(2, 6));
         end
      end
   endtask

   initial begin
      int n;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            n = LONG_HOLD_OFF;
         end else begin
            n = rx_gaps ? $urandom_range(0, 18) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", quiet);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      logic [0:19] pattern;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: one slow press and release
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      send_run(1'b1, 60);
      send_run(1'b0, 60);

      // zero debounce: flush, short single, single, hold then release, press counted on
      configure(0, 3, 1, 1, 1'b0);
      pattern = 20'b00_100_1100_11111100_100;
      for (int i = 0; i < 20; i++) send_tick(pattern[i]);

      configure(0, 1, 1, 0, 1'b1);
      random_phase(150);

      // press count saturation, then a silent end of sequence
      configure(0, 65535, 10, 65535, 1'b0);
      repeat (260) begin
         send_tick(1'b1);
         send_tick(1'b0);
      end
      send_run(1'b0, 15);

      // thresholds at the timer maximum; debounce left running into the next setting
      configure(65535, 65535, 65535, 65535, 1'b1);
      repeat (30) send_tick(logic'($urandom_range(0, 1)));

      configure(2, 12, 8, 3, 1'b1);
      tx_gaps      = 1'b0;
      hold_off_req = 1'b1;
      send_run(idle_now, 40);
      random_phase(350);
      send_run(~idle_now, 10);

      // idle level flipped while pressed
      configure(1, 20, 15, 5, 1'b0);
      random_phase(200);

      drain();
      $display("ran %0d ticks over seven register settings, %0d results checked",
               sent, checked);
      $display("events: %0d single, %0d double, %0d triple clicks, %0d holds",
               singles, doubles, triples, holds);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
